[hw/rtl/cyrpw_pkg.sv]
// Shared types, constants and helper functions of the cropping YCbCr-to-RGB pixel writer.
`timescale 1ns / 1ps
`default_nettype none

package cyrpw_pkg;

  // Field and counter widths.
  localparam int DIM_W      = 16;
  localparam int POS_W      = 17;
  localparam int SAMP_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int PIX_W      = 8;
  localparam int MCU_Q_W    = 14;

  // Fixed-point conversion: 16 fractional bits, 28-bit signed accumulator.
  localparam int COEF_FRAC = 16;
  localparam int ACC_W     = 28;

  // Coefficients rounded to nearest at 16 fractional bits.
  localparam logic signed [ACC_W-1:0] K_R_CB = 28'sd61;
  localparam logic signed [ACC_W-1:0] K_R_CR = 28'sd91861;
  localparam logic signed [ACC_W-1:0] K_G_CB = 28'sd22524;
  localparam logic signed [ACC_W-1:0] K_G_CR = 28'sd46804;
  localparam logic signed [ACC_W-1:0] K_B_CB = 28'sd116140;
  localparam logic signed [ACC_W-1:0] K_B_CR = 28'sd65;
  localparam logic signed [ACC_W-1:0] CHROMA_OFFSET = 28'sd128;

  // Reciprocal of three for values below 2^15: (2^16 + 2) / 3.
  localparam logic [29:0] RECIP_3 = 30'd21846;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_IMAGE_HEIGHT   = 2'd1,
    REG_HORIZ_SAMPLING = 2'd2,
    REG_VERT_SAMPLING  = 2'd3
  } cfg_reg_t;

  // Image geometry as seen by the position counters.
  typedef struct packed {
    logic [DIM_W-1:0] width_eff;
    logic [DIM_W-1:0] height_eff;
    logic [POS_W-1:0] pad_width;
    logic [POS_W-1:0] pad_height;
  } geom_t;

  // A visible pixel on its way to the color converter.
  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] chroma_red;
    logic             last_of_image;
  } stage_t;

  // A dimension of zero behaves as one.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    return (d == '0) ? DIM_W'(1) : d;
  endfunction

  // Sampling factors are limited to 1..4.
  function automatic logic [SAMP_W-1:0] eff_samp(input logic [SAMP_W-1:0] s);
    logic [SAMP_W-1:0] r;
    if (s == '0) begin
      r = SAMP_W'(1);
    end else if (s > SAMP_W'(4)) begin
      r = SAMP_W'(4);
    end else begin
      r = s;
    end
    return r;
  endfunction

  // Dimension rounded up to a whole number of MCUs (8 * sampling pixels).
  function automatic logic [POS_W-1:0] pad_dim(input logic [DIM_W-1:0] d,
                                               input logic [SAMP_W-1:0] s);
    logic [DIM_W-1:0]   de;
    logic [MCU_Q_W-1:0] q;
    logic [29:0]        prod;
    logic [MCU_Q_W-1:0] quot3;
    logic [1:0]         rem3;
    logic [MCU_Q_W-1:0] pq;
    de    = eff_dim(d);
    q     = MCU_Q_W'(({1'b0, de} + 17'd7) >> 3);
    prod  = 30'(q) * RECIP_3;
    quot3 = prod[29:16];
    rem3  = 2'(q - (quot3 + {quot3[MCU_Q_W-2:0], 1'b0}));
    unique case (eff_samp(s))
      3'd2:    pq = q + MCU_Q_W'(q[0]);
      3'd3:    pq = (rem3 == 2'd0) ? q : q + MCU_Q_W'(3) - MCU_Q_W'(rem3);
      3'd4:    pq = (q + MCU_Q_W'(3)) & ~MCU_Q_W'(3);
      default: pq = q;
    endcase
    return {pq, 3'b000};
  endfunction

  // Drop the fraction and saturate to 0..255.
  function automatic logic [PIX_W-1:0] to_channel(input logic signed [ACC_W-1:0] acc);
    logic [PIX_W-1:0] r;
    if (acc[ACC_W-1]) begin
      r = '0;
    end else if (|acc[ACC_W-2:COEF_FRAC+PIX_W]) begin
      r = '1;
    end else begin
      r = acc[COEF_FRAC+PIX_W-1:COEF_FRAC];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/cyrpw_ycc_if.sv]
// Stream interface that carries one Y/Cb/Cr pixel per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface cyrpw_ycc_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma;
  logic [7:0] chroma_blue;
  logic [7:0] chroma_red;

  modport source (output valid, output luma, output chroma_blue, output chroma_red,
                  input ready);
  modport sink (input valid, input luma, input chroma_blue, input chroma_red,
                output ready);
endinterface

`default_nettype wire

[hw/rtl/cyrpw_rgb_if.sv]
// Stream interface that carries one RGB pixel per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface cyrpw_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_of_image;

  modport source (output valid, output red, output green, output blue,
                  output last_of_image, input ready);
  modport sink (input valid, input red, input green, input blue,
                input last_of_image, output ready);
endinterface

`default_nettype wire

[hw/rtl/cyrpw_cfg.sv]
// Configuration registers and the padded image size derived from them.
`timescale 1ns / 1ps
`default_nettype none

module cyrpw_cfg
  import cyrpw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_enable,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output geom_t                 geom
);

  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic [SAMP_W-1:0] horiz_sampling;
  logic [SAMP_W-1:0] vert_sampling;
  logic [POS_W-1:0]  pad_width;
  logic [POS_W-1:0]  pad_height;

  // Register writes. The padded size is updated in the same cycle from the
  // written value and the other register, so it is never stale.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= DIM_W'(1);
      image_height   <= DIM_W'(1);
      horiz_sampling <= SAMP_W'(1);
      vert_sampling  <= SAMP_W'(1);
      pad_width      <= POS_W'(8);
      pad_height     <= POS_W'(8);
    end else if (cfg_write_enable) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH: begin
          image_width <= cfg_data;
          pad_width   <= pad_dim(cfg_data, horiz_sampling);
        end
        REG_IMAGE_HEIGHT: begin
          image_height <= cfg_data;
          pad_height   <= pad_dim(cfg_data, vert_sampling);
        end
        REG_HORIZ_SAMPLING: begin
          horiz_sampling <= cfg_data[SAMP_W-1:0];
          pad_width      <= pad_dim(image_width, cfg_data[SAMP_W-1:0]);
        end
        REG_VERT_SAMPLING: begin
          vert_sampling <= cfg_data[SAMP_W-1:0];
          pad_height    <= pad_dim(image_height, cfg_data[SAMP_W-1:0]);
        end
      endcase
    end
  end

  // Geometry seen by the position counters.
  assign geom.width_eff  = eff_dim(image_width);
  assign geom.height_eff = eff_dim(image_height);
  assign geom.pad_width  = pad_width;
  assign geom.pad_height = pad_height;

  // The padded sizes are whole MCU multiples that cover the visible image.
  a_pad_covers: assert property (@(posedge clk) disable iff (rst)
    (pad_width[2:0] == 3'b000) && (pad_width >= {1'b0, geom.width_eff}) &&
    (pad_height[2:0] == 3'b000) && (pad_height >= {1'b0, geom.height_eff}))
    else $error("padded size does not cover the image");

endmodule

`default_nettype wire

[hw/rtl/cyrpw_pos.sv]
// Column and row tracking, cropping, and the input stage register.
`timescale 1ns / 1ps
`default_nettype none

module cyrpw_pos
  import cyrpw_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  geom_t        geom,
  cyrpw_ycc_if.sink    pix_in,
  output stage_t       stage,
  output logic         stage_valid,
  input  logic         stage_ready
);

  logic [POS_W-1:0] column;
  logic [POS_W-1:0] row;
  logic [POS_W-1:0] column_next;
  logic [POS_W-1:0] row_next;
  logic [POS_W:0]   column_inc;
  logic [POS_W:0]   row_inc;
  logic             column_wrap;
  logic             accept;
  logic             visible;
  logic             last_pixel;
  logic             load_ready;

  // The stage takes a new pixel when empty or when its content moves on.
  assign load_ready   = !stage_valid || stage_ready;
  assign pix_in.ready = load_ready;
  assign accept       = pix_in.valid && load_ready;

  // Cropping against the visible image.
  assign visible    = (column < {1'b0, geom.width_eff}) && (row < {1'b0, geom.height_eff});
  assign last_pixel = (column == {1'b0, geom.width_eff - DIM_W'(1)}) &&
                      (row == {1'b0, geom.height_eff - DIM_W'(1)});

  // Raster advance over the padded image.
  always_comb begin
    column_inc  = {1'b0, column} + (POS_W+1)'(1);
    row_inc     = {1'b0, row} + (POS_W+1)'(1);
    column_wrap = column_inc >= {1'b0, geom.pad_width};
    column_next = column_wrap ? '0 : column_inc[POS_W-1:0];
    if (!column_wrap) begin
      row_next = row;
    end else if (row_inc >= {1'b0, geom.pad_height}) begin
      row_next = '0;
    end else begin
      row_next = row_inc[POS_W-1:0];
    end
  end

  // Position counters and stage valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      column      <= '0;
      row         <= '0;
      stage_valid <= 1'b0;
    end else begin
      if (accept) begin
        column <= column_next;
        row    <= row_next;
      end
      if (load_ready) begin
        stage_valid <= accept && visible;
      end
    end
  end

  // Stage payload for kept pixels.
  always_ff @(posedge clk) begin
    if (accept && visible) begin
      stage.luma          <= pix_in.luma;
      stage.chroma_blue   <= pix_in.chroma_blue;
      stage.chroma_red    <= pix_in.chroma_red;
      stage.last_of_image <= last_pixel;
    end
  end

  // The row moves only on a transfer.
  a_row_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(row))
    else $error("row counter moved without an input transfer");

  // A cropped pixel never enters the stage.
  a_crop: assert property (@(posedge clk) disable iff (rst)
    (accept && !visible) |=> !stage_valid)
    else $error("cropped pixel entered the stage");

  // The column either steps by one or wraps to zero.
  a_column_step: assert property (@(posedge clk) disable iff (rst)
    accept |=> (column == '0) || (column == $past(column) + POS_W'(1)))
    else $error("column counter skipped");

endmodule

`default_nettype wire

[hw/rtl/cyrpw_csc.sv]
// Fixed-point YCbCr-to-RGB conversion with saturation, and the output register.
`timescale 1ns / 1ps
`default_nettype none

module cyrpw_csc
  import cyrpw_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  stage_t       stage,
  input  logic         stage_valid,
  output logic         stage_ready,
  cyrpw_rgb_if.source  pix_out
);

  logic signed [ACC_W-1:0] y_scaled;
  logic signed [ACC_W-1:0] cb;
  logic signed [ACC_W-1:0] cr;
  logic signed [ACC_W-1:0] acc_red;
  logic signed [ACC_W-1:0] acc_green;
  logic signed [ACC_W-1:0] acc_blue;
  logic                    out_valid;
  logic [PIX_W-1:0]        red;
  logic [PIX_W-1:0]        green;
  logic [PIX_W-1:0]        blue;
  logic                    last_of_image;

  // The output register frees up when empty or when its result is taken.
  assign stage_ready = !out_valid || pix_out.ready;

  // Matrix with constant coefficients; the sums are exact in 28 bits.
  always_comb begin
    y_scaled  = signed'({{(ACC_W-PIX_W-COEF_FRAC){1'b0}}, stage.luma, {COEF_FRAC{1'b0}}});
    cb        = signed'(ACC_W'(stage.chroma_blue)) - CHROMA_OFFSET;
    cr        = signed'(ACC_W'(stage.chroma_red)) - CHROMA_OFFSET;
    acc_red   = y_scaled - K_R_CB * cb + K_R_CR * cr;
    acc_green = y_scaled - K_G_CB * cb - K_G_CR * cr;
    acc_blue  = y_scaled + K_B_CB * cb + K_B_CR * cr;
  end

  // Output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_ready) begin
      out_valid <= stage_valid;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (stage_ready && stage_valid) begin
      red           <= to_channel(acc_red);
      green         <= to_channel(acc_green);
      blue          <= to_channel(acc_blue);
      last_of_image <= stage.last_of_image;
    end
  end

  assign pix_out.valid         = out_valid;
  assign pix_out.red           = red;
  assign pix_out.green         = green;
  assign pix_out.blue          = blue;
  assign pix_out.last_of_image = last_of_image;

  // A pixel that leaves the stage is presented at the output next cycle.
  a_stage_to_out: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && stage_ready) |=> out_valid)
    else $error("converted pixel lost between stage and output");

endmodule

`default_nettype wire

[hw/rtl/cropping_ycbcr_to_rgb_pixel_writer.sv]
// Top level of the cropping YCbCr-to-RGB pixel writer.
//
// pix_in takes one Y/Cb/Cr pixel per transfer, in raster order of the image
// padded up to whole MCUs (8 * horiz_sampling by 8 * vert_sampling pixels).
// Pixels right of image_width or below image_height are consumed and dropped.
// Each visible pixel leaves on pix_out as one saturated RGB transfer; the
// flag last_of_image marks the bottom-right visible pixel. After the last
// padded pixel the counters wrap and the next image begins.
// The plain write port sets the four registers; a write is taken at any
// edge with cfg_write_enable high and should be made while no pixel is in flight.
// A kept pixel passes through the input stage register and then, after the
// conversion, through the output register before it is presented on pix_out.
// Throughput: one pixel per cycle while pix_out does not stall; every stage
// holds one pixel and moves it on whenever the next stage is free.
// When pix_out stalls, the output register holds and the input stage, if empty,
// still accepts one more pixel before pix_in.ready drops; cropped pixels are
// still accepted while both registers hold a pixel only if the stage can move.
// Reset clears both counters and sets a 1x1 image with sampling factors of 1.
`timescale 1ns / 1ps
`default_nettype none

module cropping_ycbcr_to_rgb_pixel_writer
  import cyrpw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_enable,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  cyrpw_ycc_if.sink             pix_in,
  cyrpw_rgb_if.source           pix_out
);

  geom_t  geom;
  stage_t stage;
  logic   stage_valid;
  logic   stage_ready;

  // Registers and padded size.
  cyrpw_cfg u_cfg (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .geom             (geom)
  );

  // Position tracking and cropping.
  cyrpw_pos u_pos (
    .clk         (clk),
    .rst         (rst),
    .geom        (geom),
    .pix_in      (pix_in),
    .stage       (stage),
    .stage_valid (stage_valid),
    .stage_ready (stage_ready)
  );

  // Color conversion and output register.
  cyrpw_csc u_csc (
    .clk         (clk),
    .rst         (rst),
    .stage       (stage),
    .stage_valid (stage_valid),
    .stage_ready (stage_ready),
    .pix_out     (pix_out)
  );

endmodule

`default_nettype wire
